/* hdl/fpc_pkg.sv */
// Shared constants, types and rounding functions for the float/PCM sample converter.
package fpc_pkg;

    localparam logic KIND_F2P = 1'b0;
    localparam logic KIND_P2F = 1'b1;

    // Pipeline depth of each conversion path, and of the whole block.
    localparam int PATH_STAGES = 6;
    localparam int LATENCY     = PATH_STAGES + 1;

    localparam logic [23:0] PCM_MIN   = 24'h800000;
    localparam logic [23:0] MINUS_ONE = 24'hFFFFFF;
    localparam logic [23:0] MINUS_TWO = 24'hFFFFFE;
    // Significand of 8388607.5 and of the float32 value of 1 / 8388607.5.
    localparam logic [23:0] SCALE_MANT = 24'hFFFFFF;
    localparam logic [23:0] COEF_MANT  = 24'h800001;
    // Largest significand, which just below one gives 1 - 2^-24.
    localparam logic [23:0] MANT_MAX   = 24'hFFFFFF;
    // One half in the Q23.23 fixed-point format of the negative path.
    localparam logic [46:0] HALF_Q23   = 47'h400000;
    // Smallest significand at or above 1.5, for the threshold 3 * 2^-26.
    localparam logic [23:0] MANT_1P5   = 24'hC00000;
    localparam logic [7:0]  EXP_ONE    = 8'd127;

    typedef struct packed {
        logic [1:0]  einc;
        logic [23:0] mant;
    } rnd_t;

    // Rounds a 48-bit significand product to 24 bits, nearest even.
    function automatic rnd_t norm_round(input logic [47:0] p);
        rnd_t        r;
        logic [23:0] m;
        logic        g;
        logic        st;
        logic [24:0] sum;
        if (p[47])
        begin
            m  = p[47:24];
            g  = p[23];
            st = |p[22:0];
        end
        else
        begin
            m  = p[46:23];
            g  = p[22];
            st = |p[21:0];
        end
        sum    = {1'b0, m} + {24'd0, (g && (st || m[0]))};
        r.einc = {1'b0, p[47]} + {1'b0, sum[24]};
        r.mant = sum[24] ? 24'h800000 : sum[23:0];
        return r;
    endfunction

    // Rounds a Q23.23 value of at least 1.0 to 24 significant bits, nearest even.
    function automatic logic [46:0] round24(input logic [46:0] v);
        logic [4:0]  s;
        logic [46:0] unit;
        logic [46:0] low;
        logic [46:0] keep;
        logic        g;
        logic        st;
        logic        l;
        s = '0;
        for (int i = 0; i < 24; i++)
        begin
            if (v[23 + i])
                s = 5'(i);
        end
        unit = 47'd1 << s;
        low  = unit - 47'd1;
        keep = v & ~low;
        g    = |(v & (unit >> 1));
        st   = |(v & (low >> 1));
        l    = |(v & unit);
        if (g && (st || l))
            keep = keep + unit;
        return keep;
    endfunction

endpackage

/* hdl/fpc_f2p.sv */
// Float32 to signed 24-bit PCM conversion pipeline, six register stages.
module fpc_f2p
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] float_in,
    output logic        out_valid,
    output logic [23:0] result
);

    logic [fpc_pkg::PATH_STAGES-1:0] v_reg;

    // Stage 1: unpack and clamp to [-1, 1].
    logic        s1_sign_reg, s1_nan_reg, s1_tiny_reg;
    logic [7:0]  s1_exp_reg;
    logic [23:0] s1_mant_reg;
    logic [7:0]  exp_in;
    logic [22:0] frac_in;
    logic        big_in;
    logic [7:0]  exp_next;
    logic [22:0] frac_next;

    // Stage 2: significand product.
    logic        s2_sign_reg, s2_nan_reg, s2_tiny_reg;
    logic [7:0]  s2_exp_reg;
    logic [47:0] s2_prod_reg;

    // Stage 3: rounded product g = m * 2^(L-23).
    logic              s3_sign_reg, s3_nan_reg, s3_tiny_reg;
    logic [23:0]       s3_mant_reg;
    logic signed [8:0] s3_lead_reg;
    fpc_pkg::rnd_t     rnd3;

    // Stage 4: direct result or start of the negative half-step path.
    logic        s4_use_y_reg;
    logic [23:0] s4_r_reg;
    logic [46:0] s4_y_reg;
    logic        pos_small;
    logic        use_y_next;
    logic [23:0] r_next;

    // Stages 5 and 6: two float additions of one half.
    logic        s5_use_y_reg;
    logic [23:0] s5_r_reg;
    logic [46:0] s5_y_reg;
    logic [46:0] z6;
    logic [23:0] s6_r_reg;

    assign exp_in  = float_in[30:23];
    assign frac_in = float_in[22:0];
    assign big_in  = (exp_in > fpc_pkg::EXP_ONE) ||
                     (exp_in == fpc_pkg::EXP_ONE && frac_in != 23'd0);
    assign exp_next  = big_in ? fpc_pkg::EXP_ONE : exp_in;
    assign frac_next = big_in ? 23'd0 : frac_in;

    assign rnd3 = fpc_pkg::norm_round(s2_prod_reg);

    assign pos_small = (s3_lead_reg < -9'sd25) ||
                       (s3_lead_reg == -9'sd25 && s3_mant_reg < fpc_pkg::MANT_1P5);

    always_comb
    begin
        use_y_next = 1'b0;
        r_next     = '0;
        if (s3_nan_reg)
            r_next = fpc_pkg::PCM_MIN;
        else if (s3_tiny_reg)
            r_next = fpc_pkg::MINUS_ONE;
        else if (!s3_sign_reg)
        begin
            if (s3_lead_reg[8])
                r_next = pos_small ? fpc_pkg::MINUS_ONE : 24'd0;
            else
                r_next = s3_mant_reg >> (5'd23 - s3_lead_reg[4:0]);
        end
        else if (s3_lead_reg[8])
        begin
            // A magnitude just under one rounds up to 1.5 and then to 2.
            if (s3_lead_reg == -9'sd1 && s3_mant_reg == fpc_pkg::MANT_MAX)
                r_next = fpc_pkg::MINUS_TWO;
            else
                r_next = fpc_pkg::MINUS_ONE;
        end
        else
            use_y_next = 1'b1;
    end

    assign z6 = fpc_pkg::round24(s5_y_reg + fpc_pkg::HALF_Q23);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[fpc_pkg::PATH_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        s1_sign_reg <= float_in[31];
        s1_nan_reg  <= (exp_in == 8'hFF) && (frac_in != 23'd0);
        s1_tiny_reg <= (exp_in == 8'd0);
        s1_exp_reg  <= exp_next;
        s1_mant_reg <= {1'b1, frac_next};

        s2_sign_reg <= s1_sign_reg;
        s2_nan_reg  <= s1_nan_reg;
        s2_tiny_reg <= s1_tiny_reg;
        s2_exp_reg  <= s1_exp_reg;
        s2_prod_reg <= s1_mant_reg * fpc_pkg::SCALE_MANT;

        s3_sign_reg <= s2_sign_reg;
        s3_nan_reg  <= s2_nan_reg;
        s3_tiny_reg <= s2_tiny_reg;
        s3_mant_reg <= rnd3.mant;
        s3_lead_reg <= $signed({1'b0, s2_exp_reg}) - 9'sd105 + $signed({7'd0, rnd3.einc});

        s4_use_y_reg <= use_y_next;
        s4_r_reg     <= r_next;
        s4_y_reg     <= (47'(s3_mant_reg) << s3_lead_reg[4:0]) + fpc_pkg::HALF_Q23;

        s5_use_y_reg <= s4_use_y_reg;
        s5_r_reg     <= s4_r_reg;
        s5_y_reg     <= fpc_pkg::round24(s4_y_reg);

        s6_r_reg <= s5_use_y_reg ? (24'd0 - z6[46:23]) : s5_r_reg;
    end

    assign out_valid = v_reg[fpc_pkg::PATH_STAGES-1];
    assign result    = s6_r_reg;

endmodule

/* hdl/fpc_p2f.sv */
// Signed 24-bit PCM to float32 conversion pipeline, six register stages.
module fpc_p2f
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [23:0] sample_in,
    output logic        out_valid,
    output logic [31:0] result
);

    logic [fpc_pkg::PATH_STAGES-1:0] v_reg;

    logic [24:0] n_ext;
    logic [24:0] n_neg;
    logic        s1_sign_reg;
    logic [23:0] s1_mag_reg;

    logic [4:0]  lead_q;
    logic        s2_sign_reg;
    logic [4:0]  s2_q_reg;
    logic [23:0] s2_mant_reg;

    logic        s3_sign_reg;
    logic [4:0]  s3_q_reg;
    logic [47:0] s3_prod_reg;

    fpc_pkg::rnd_t rnd4;
    logic [7:0]    exp4;
    logic          over4;
    logic [31:0]   s4_res_reg;
    logic [31:0]   s5_res_reg;
    logic [31:0]   s6_res_reg;

    // The sample plus one half is the odd integer 2i+1 times one half.
    assign n_ext = {sample_in, 1'b1};
    assign n_neg = ~n_ext + 25'd1;

    always_comb
    begin
        lead_q = '0;
        for (int i = 0; i < 24; i++)
        begin
            if (s1_mag_reg[i])
                lead_q = 5'(i);
        end
    end

    assign rnd4  = fpc_pkg::norm_round(s3_prod_reg);
    assign exp4  = {3'd0, s3_q_reg} + 8'd103 + {6'd0, rnd4.einc};
    assign over4 = (exp4 > fpc_pkg::EXP_ONE) ||
                   (exp4 == fpc_pkg::EXP_ONE && rnd4.mant[22:0] != 23'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[fpc_pkg::PATH_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        s1_sign_reg <= sample_in[23];
        s1_mag_reg  <= sample_in[23] ? n_neg[23:0] : n_ext[23:0];

        s2_sign_reg <= s1_sign_reg;
        s2_q_reg    <= lead_q;
        s2_mant_reg <= s1_mag_reg << (5'd23 - lead_q);

        s3_sign_reg <= s2_sign_reg;
        s3_q_reg    <= s2_q_reg;
        s3_prod_reg <= s2_mant_reg * fpc_pkg::COEF_MANT;

        s4_res_reg <= over4 ? {s3_sign_reg, fpc_pkg::EXP_ONE, 23'd0}
                            : {s3_sign_reg, exp4, rnd4.mant[22:0]};
        s5_res_reg <= s4_res_reg;
        s6_res_reg <= s5_res_reg;
    end

    assign out_valid = v_reg[fpc_pkg::PATH_STAGES-1];
    assign result    = s6_res_reg;

endmodule

/* hdl/float_pcm24_sample_converter.sv */
// Top level of the float32 / 24-bit PCM sample converter.
// Pipeline: an accepted word passes its path's stages, then the output register shows
// its result with done high; the depth is set by the float multiply and two roundings.
// Throughput: one word per cycle; busy is always low, since the receiver cannot stall.
// Reset: rst_n clears all valid bits asynchronously; words in flight are dropped.
module float_pcm24_sample_converter
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [31:0]        float_in,
    input  logic signed [23:0] sample_in,
    output logic               done,
    output logic signed [23:0] sample_out,
    output logic [31:0]        float_out
);

    logic        accept;
    logic        f2p_valid;
    logic        p2f_valid;
    logic [23:0] f2p_result;
    logic [31:0] p2f_result;

    logic        done_reg;
    logic [23:0] sample_reg;
    logic [31:0] float_reg;

    // Both paths are fully pipelined, so a new word is taken on every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Each direction has its own pipeline of equal depth; kind steers the
    // word into one of them, and only that one raises its valid bit.
    fpc_f2p u_f2p
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && kind == fpc_pkg::KIND_F2P),
        .float_in  (float_in),
        .out_valid (f2p_valid),
        .result    (f2p_result)
    );

    fpc_p2f u_p2f
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && kind == fpc_pkg::KIND_P2F),
        .sample_in (sample_in),
        .out_valid (p2f_valid),
        .result    (p2f_result)
    );

    // Output register: the field that does not belong to the word's
    // direction is forced to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= f2p_valid || p2f_valid;
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= f2p_valid ? f2p_result : 24'd0;
        float_reg  <= p2f_valid ? p2f_result : 32'd0;
    end

    assign done       = done_reg;
    assign sample_out = $signed(sample_reg);
    assign float_out  = float_reg;

endmodule

/* hdl/fpc_chk.sv */
// Port-level checker for the sample converter, bound to the top level.
module fpc_chk
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               kind,
    input logic [31:0]        float_in,
    input logic               done,
    input logic signed [23:0] sample_out,
    input logic [31:0]        float_out
);

    logic [2:0] cnt_reg;
    logic       armed;
    logic       nan_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cnt_reg != 3'(fpc_pkg::LATENCY))
            cnt_reg <= cnt_reg + 3'd1;
    end

    assign armed  = (cnt_reg == 3'(fpc_pkg::LATENCY));
    assign nan_in = (float_in[30:23] == 8'hFF) && (float_in[22:0] != 23'd0);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        armed |-> (done == $past(start && !busy, 7)))
        else $error("result word missing or extra");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (armed && done) |->
        (($past(kind, 7) == fpc_pkg::KIND_F2P && float_out == 32'd0) ||
         ($past(kind, 7) == fpc_pkg::KIND_P2F && sample_out == 24'sd0)))
        else $error("unused result field not zero");

    a_nan_min: assert property (@(posedge clk) disable iff (!rst_n)
        (armed && done && $past(kind == fpc_pkg::KIND_F2P && nan_in, 7)) |->
        (sample_out == $signed(fpc_pkg::PCM_MIN)))
        else $error("NaN did not give negative full scale");

endmodule

bind float_pcm24_sample_converter fpc_chk u_fpc_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .float_in   (float_in),
    .done       (done),
    .sample_out (sample_out),
    .float_out  (float_out)
);
